// ----- sv/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types, constants and helpers for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int COUNTER_BITS_DEF = 16;

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_TEMPERATURE = 2'd0,
    REG_TIMEOUT     = 2'd1,
    REG_TRIGGER     = 2'd2,
    REG_FREE_MODE   = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_HIGH = 2'd3
  } phase_t;

  typedef struct packed {
    logic start_req;
    logic echo;
  } tick_t;

  typedef struct packed {
    logic        trigger;
    logic        done_res;
    logic        timed_out;
    logic [18:0] distance_q8;
    logic        busy_res;
  } result_t;

  typedef struct packed {
    logic trigger;
    logic done_res;
    logic timed_out;
    logic busy_res;
    logic measured;
  } ctl_t;

  localparam logic [6:0]  TEMP_RESET    = 7'd20;
  localparam logic [15:0] TIMEOUT_RESET = 16'd30000;
  localparam logic [7:0]  TRIGGER_RESET = 8'd10;
  localparam logic [6:0]  TEMP_MAX      = 7'd100;

  localparam logic [18:0] SPEED_BASE  = 19'd331300;
  localparam logic [9:0]  SPEED_SLOPE = 10'd606;

  localparam logic [34:0] FREE_LIMIT = 35'd26000000000;

  localparam logic [16:0] DIV_K     = 17'd78125;
  localparam logic [17:0] DIV_K2    = 18'd156250;
  localparam logic [19:0] RECIP     = 20'd879609;
  localparam logic [35:0] SAT_X     = 36'd40960000000;
  localparam logic [18:0] DIST_MAX  = 19'h7FFFF;

  function automatic logic [18:0] speed_of(input logic [6:0] t);
    logic [6:0] tc;
    tc = (t > TEMP_MAX) ? TEMP_MAX : t;
    return SPEED_BASE + ({12'b0, tc} * {9'b0, SPEED_SLOPE});
  endfunction

endpackage

// ----- sv/uer_dist.sv -----
// ----------------------------------------------------------------------------
// uer_dist
// Distance pipeline: pulse width times speed, then division by 78125 through
// a reciprocal estimate with a remainder correction, and the result register.
// ----------------------------------------------------------------------------
module uer_dist
  import uer_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  uer_pkg::ctl_t           ctl,
  input  logic [COUNTER_BITS-1:0] width,
  input  logic [18:0]             speed,
  output logic                    result_valid,
  input  logic                    result_stall,
  output uer_pkg::result_t        result
);

  localparam int PW = COUNTER_BITS + 19;
  localparam int XW = (PW > 36) ? PW : 36;

  logic          v2, v3, v4;
  ctl_t          ctl2, ctl3, ctl4;
  logic [PW-1:0] x2;
  logic [35:0]   x3;
  logic [18:0]   q3, q4;
  logic          sat3, sat4;
  logic [17:0]   r4;

  logic          ld2, ld3, ld4, ld_o;
  logic [35:0]   x2_36;
  logic [39:0]   qprod;
  logic [35:0]   qk;
  logic [35:0]   rem;
  logic [18:0]   q_fix;

  assign ld_o = !result_valid || !result_stall;
  assign ld4  = !v4 || ld_o;
  assign ld3  = !v3 || ld4;
  assign ld2  = !v2 || ld3;
  assign in_stall = !ld2;

  assign x2_36 = 36'(x2);
  assign qprod = {20'b0, x2_36[35:16]} * {20'b0, RECIP};
  assign qk    = {17'b0, q3} * {19'b0, DIV_K};
  assign rem   = x3 - qk;

  always_comb begin
    if (r4 >= DIV_K2) begin
      q_fix = q4 + 19'd2;
    end else if (r4 >= 18'(DIV_K)) begin
      q_fix = q4 + 19'd1;
    end else begin
      q_fix = q4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ld2) begin
        v2 <= in_valid;
      end
      if (ld3) begin
        v3 <= v2;
      end
      if (ld4) begin
        v4 <= v3;
      end
      if (ld_o) begin
        result_valid <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && in_valid) begin
      ctl2 <= ctl;
      x2   <= {19'b0, width} * {{(PW-19){1'b0}}, speed};
    end
    if (ld3 && v2) begin
      ctl3 <= ctl2;
      x3   <= x2_36;
      q3   <= qprod[38:20];
      sat3 <= XW'(x2) >= XW'(SAT_X);
    end
    if (ld4 && v3) begin
      ctl4 <= ctl3;
      q4   <= q3;
      r4   <= rem[17:0];
      sat4 <= sat3;
    end
    if (ld_o && v4) begin
      result.trigger   <= ctl4.trigger;
      result.done_res  <= ctl4.done_res;
      result.timed_out <= ctl4.timed_out;
      result.busy_res  <= ctl4.busy_res;
      if (!ctl4.measured) begin
        result.distance_q8 <= '0;
      end else if (sat4) begin
        result.distance_q8 <= DIST_MAX;
      end else begin
        result.distance_q8 <= q_fix;
      end
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v3 && !sat3 |-> rem < 36'(DIV_K2) + 36'(DIV_K))
    else $error("reciprocal estimate off by more than two");

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.timed_out |-> result.done_res && result.distance_q8 == '0)
    else $error("timed out item carries a distance");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.done_res |-> result.distance_q8 == '0)
    else $error("distance given without a finished measurement");

endmodule

// ----- sv/ultrasonic_echo_ranger.sv -----
// A result item passes from the state register through v2, v3, v4 and the result register.
// Throughput: one tick item per cycle while tick_stall is low; the measurement state updates at accept.
// The distance division runs in a 4-stage pipeline behind the state register.
// Reset clears the measurement state and the pipeline and loads the register
// defaults: 20 C, 30000 us timeout, 10 us trigger, timeout mode.
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Trigger pulse generation, echo pulse timing with timeout or free-mode
// retrigger, and distance conversion with speed of sound by temperature.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uer_pkg::ADDR_BITS-1:0] paddr,
  input  logic [uer_pkg::DATA_BITS-1:0] pwdata,
  output logic [uer_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  input  logic                          tick_valid,
  output logic                          tick_stall,
  input  uer_pkg::tick_t                tick,
  output logic                          result_valid,
  input  logic                          result_stall,
  output uer_pkg::result_t              result
);

  localparam int CB = COUNTER_BITS;
  localparam int WW = (CB > 16) ? CB : 16;
  localparam int FW = (CB + 19 > 35) ? CB + 19 : 35;

  logic [6:0]  temperature_c;
  logic [15:0] timeout_us;
  logic [7:0]  trigger_us;
  logic        free_mode;
  logic [18:0] speed;

  phase_t        phase, phase_next;
  logic [7:0]    pulse_count, pulse_count_next;
  logic [CB-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [CB-1:0] echo_width, echo_width_next;
  logic          echo_last;
  ctl_t          ctl_next;

  logic          s1_v;
  ctl_t          s1_ctl;
  logic [CB-1:0] s1_width;

  logic          dist_stall;
  logic          ld1, tick_accept;
  logic          cfg_write;
  reg_index_t    cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      temperature_c <= TEMP_RESET;
      timeout_us    <= TIMEOUT_RESET;
      trigger_us    <= TRIGGER_RESET;
      free_mode     <= 1'b0;
      speed         <= speed_of(TEMP_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEMPERATURE: begin
          temperature_c <= pwdata[6:0];
          speed         <= speed_of(pwdata[6:0]);
        end
        REG_TIMEOUT:   timeout_us <= pwdata[15:0];
        REG_TRIGGER:   trigger_us <= pwdata[7:0];
        REG_FREE_MODE: free_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_TEMPERATURE: prdata = 32'(temperature_c);
      REG_TIMEOUT:     prdata = 32'(timeout_us);
      REG_TRIGGER:     prdata = 32'(trigger_us);
      REG_FREE_MODE:   prdata = 32'(free_mode);
      default:         prdata = '0;
    endcase
  end

  assign ld1         = !s1_v || !dist_stall;
  assign tick_stall  = !ld1;
  assign tick_accept = tick_valid && ld1;

  always_comb begin
    logic [7:0]     tlen;
    logic [15:0]    tmo;
    logic           waiting;
    logic [CB+18:0] free_prod;
    tlen    = (trigger_us == 8'd0) ? 8'd1 : trigger_us;
    tmo     = (timeout_us == 16'd0) ? 16'd1 : timeout_us;
    waiting = 1'b0;
    phase_next         = phase;
    pulse_count_next   = pulse_count;
    elapsed_ticks_next = elapsed_ticks;
    echo_width_next    = echo_width;
    ctl_next           = '0;

    if (tick.start_req) begin
      phase_next         = PH_TRIG;
      pulse_count_next   = '0;
      elapsed_ticks_next = '0;
      echo_width_next    = '0;
    end

    case (phase_next)
      PH_TRIG: begin
        ctl_next.trigger = 1'b1;
        pulse_count_next = pulse_count_next + 8'd1;
        if (pulse_count_next >= tlen) begin
          phase_next         = PH_WAIT;
          pulse_count_next   = '0;
          elapsed_ticks_next = '0;
        end
      end
      PH_WAIT: begin
        if (!(&elapsed_ticks_next)) begin
          elapsed_ticks_next = elapsed_ticks_next + CB'(1);
        end
        if (tick.echo && !echo_last) begin
          phase_next      = PH_HIGH;
          echo_width_next = CB'(1);
        end
        waiting = 1'b1;
      end
      PH_HIGH: begin
        if (!(&elapsed_ticks_next)) begin
          elapsed_ticks_next = elapsed_ticks_next + CB'(1);
        end
        if (tick.echo) begin
          if (!(&echo_width_next)) begin
            echo_width_next = echo_width_next + CB'(1);
          end
          waiting = 1'b1;
        end else begin
          ctl_next.done_res = 1'b1;
          ctl_next.measured = 1'b1;
          phase_next        = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase

    free_prod = {19'b0, elapsed_ticks_next} * {{CB{1'b0}}, speed};
    if (waiting) begin
      if (!free_mode) begin
        if (WW'(elapsed_ticks_next) >= WW'(tmo) || (&elapsed_ticks_next)) begin
          ctl_next.done_res  = 1'b1;
          ctl_next.timed_out = 1'b1;
          ctl_next.measured  = 1'b0;
          phase_next         = PH_IDLE;
        end
      end else if (tick.echo && FW'(free_prod) > FW'(FREE_LIMIT)) begin
        phase_next         = PH_TRIG;
        pulse_count_next   = '0;
        elapsed_ticks_next = '0;
        echo_width_next    = '0;
      end
    end

    ctl_next.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      pulse_count   <= '0;
      elapsed_ticks <= '0;
      echo_width    <= '0;
      echo_last     <= 1'b0;
      s1_v          <= 1'b0;
    end else begin
      if (tick_accept) begin
        phase         <= phase_next;
        pulse_count   <= pulse_count_next;
        elapsed_ticks <= elapsed_ticks_next;
        echo_width    <= echo_width_next;
        echo_last     <= tick.echo;
      end
      if (ld1) begin
        s1_v <= tick_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      s1_ctl   <= ctl_next;
      s1_width <= echo_width_next;
    end
  end

  uer_dist #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_dist (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s1_v),
    .in_stall     (dist_stall),
    .ctl          (s1_ctl),
    .width        (s1_width),
    .speed        (speed),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_start_trig: assert property (@(posedge clk) disable iff (rst)
    tick_accept && tick.start_req |=> s1_v && s1_ctl.trigger)
    else $error("start item did not drive the trigger");

  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    s1_v && s1_ctl.trigger |-> s1_ctl.busy_res)
    else $error("trigger driven while not busy");

  a_pulse_clear: assert property (@(posedge clk) disable iff (rst)
    phase != PH_TRIG |-> pulse_count == '0)
    else $error("pulse counter left over outside the trigger phase");

endmodule

// ----- verif/ultrasonic_echo_ranger_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_tb
// Self-checking bench for the echo ranger. Microsecond ticks go in over the
// valid/stall channel, and a scoreboard class predicts every result item
// from its own model of the trigger, echo timing and distance conversion.
// A short directed part covers zero and out-of-range settings, echo during
// trigger and restarts. Random phases follow, with mostly well-formed
// measurements, under each idling pattern.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_tb;
  import uer_pkg::*;

  localparam int QUIET_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int SENDER_IDLE     = 87;
  localparam int BOTH_IDLE       = 20;
  localparam int ITEM_TARGET     = 1050;
  localparam int PHASES          = 12;
  localparam int MIN_PHASE_ITEMS = 24;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  class ranger_scoreboard;
    localparam longint unsigned SOUND_BASE  = 331300;
    localparam longint unsigned SOUND_SLOPE = 606;
    localparam longint unsigned RETRIG_AT   = 64'd26000000000;
    localparam longint unsigned DIST_DIV    = 20000000;
    localparam longint unsigned DIST_TOP    = 524287;

    logic [6:0]  temp_c;
    logic [15:0] timeout;
    logic [7:0]  trig_len;
    logic        free_run;

    phase_t      phase;
    logic [7:0]  pulses;
    logic [15:0] elapsed;
    logic [15:0] width;
    logic        echo_prev;

    result_t readings_due[$];
    int      errors;
    int      checked;

    function new();
      temp_c    = 7'd20;
      timeout   = 16'd30000;
      trig_len  = 8'd10;
      free_run  = 1'b0;
      phase     = PH_IDLE;
      pulses    = '0;
      elapsed   = '0;
      width     = '0;
      echo_prev = 1'b0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [31:0] v);
      case (idx)
        REG_TEMPERATURE: temp_c = v[6:0];
        REG_TIMEOUT:     timeout = v[15:0];
        REG_TRIGGER:     trig_len = v[7:0];
        REG_FREE_MODE:   free_run = v[0];
        default: ;
      endcase
    endfunction

    function result_t next_reading(tick_t t);
      result_t r;
      logic [7:0] tlen;
      logic [15:0] tmo;
      logic waiting;
      longint unsigned spd;
      longint unsigned dist_q8;
      r = '0;
      waiting = 1'b0;
      tlen = (trig_len == 8'd0) ? 8'd1 : trig_len;
      tmo = (timeout == 16'd0) ? 16'd1 : timeout;
      spd = SOUND_BASE + SOUND_SLOPE * ((temp_c > 7'd100) ? 64'd100 : 64'(temp_c));
      if (t.start_req) begin
        phase = PH_TRIG;
        pulses = '0;
        elapsed = '0;
        width = '0;
      end
      case (phase)
        PH_TRIG: begin
          r.trigger = 1'b1;
          pulses = pulses + 8'd1;
          if (pulses >= tlen) begin
            phase = PH_WAIT;
            pulses = '0;
            elapsed = '0;
          end
        end
        PH_WAIT: begin
          if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
          if (t.echo && !echo_prev) begin
            phase = PH_HIGH;
            width = 16'd1;
          end
          waiting = 1'b1;
        end
        PH_HIGH: begin
          if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
          if (t.echo) begin
            if (width != 16'hFFFF) width = width + 16'd1;
            waiting = 1'b1;
          end else begin
            dist_q8 = 64'(width) * spd * 64'd256 / DIST_DIV;
            if (dist_q8 > DIST_TOP) dist_q8 = DIST_TOP;
            r.done_res = 1'b1;
            r.distance_q8 = dist_q8[18:0];
            phase = PH_IDLE;
          end
        end
        default: phase = PH_IDLE;
      endcase
      if (waiting) begin
        if (!free_run) begin
          if (elapsed >= tmo || elapsed == 16'hFFFF) begin
            r.done_res = 1'b1;
            r.timed_out = 1'b1;
            r.distance_q8 = '0;
            phase = PH_IDLE;
          end
        end else if (t.echo && 64'(elapsed) * spd > RETRIG_AT) begin
          phase = PH_TRIG;
          pulses = '0;
          elapsed = '0;
          width = '0;
        end
      end
      echo_prev = t.echo;
      r.busy_res = (phase != PH_IDLE);
      return r;
    endfunction

    function void note_tick(tick_t t);
      readings_due.push_back(next_reading(t));
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("MISMATCH at reading %0d: %s got %0d expected %0d", checked, what, got, want);
      errors++;
    endtask

    task check_reading(result_t got);
      result_t want;
      if (readings_due.size() == 0) begin
        report("unexpected reading", 64'(got), 64'(0));
      end else begin
        want = readings_due.pop_front();
        if (got.trigger !== want.trigger) begin
          report("trigger", 64'(got.trigger), 64'(want.trigger));
        end
        if (got.done_res !== want.done_res) begin
          report("done_res", 64'(got.done_res), 64'(want.done_res));
        end
        if (got.timed_out !== want.timed_out) begin
          report("timed_out", 64'(got.timed_out), 64'(want.timed_out));
        end
        if (got.distance_q8 !== want.distance_q8) begin
          report("distance_q8", 64'(got.distance_q8), 64'(want.distance_q8));
        end
        if (got.busy_res !== want.busy_res) begin
          report("busy_res", 64'(got.busy_res), 64'(want.busy_res));
        end
      end
      checked++;
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 tick_valid;
  logic                 tick_stall;
  tick_t                tick;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;

  ranger_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles = 0;
  int items_sent;

  ultrasonic_echo_ranger dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (tick_valid && !tick_stall) sb.note_tick(tick);
      if (result_valid && !result_stall) sb.check_reading(result);
      if ((tick_valid && !tick_stall) || (result_valid && !result_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic set_idling(idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? SENDER_IDLE : (mode == IDLE_BOTH) ? BOTH_IDLE : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? SENDER_IDLE : (mode == IDLE_BOTH) ? BOTH_IDLE : 0;
  endtask

  task automatic send_tick(logic start, logic echo);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick <= '{start_req: start, echo: echo};
    do @(posedge clk); while (tick_stall);
    items_sent++;
  endtask

  task automatic send_run(logic start, logic echo, int count);
    repeat (count) send_tick(start, echo);
  endtask

  task automatic drain();
    tick_valid <= 1'b0;
    while (sb.readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(reg_index_t idx, logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == REG_TEMPERATURE) ? 32'h7F : (idx == REG_TIMEOUT) ? 32'hFFFF :
           (idx == REG_TRIGGER) ? 32'hFF : 32'h1;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val & mask);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== (val & mask)) sb.report("register readback", 64'(prdata), 64'(val & mask));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [31:0] temp, logic [31:0] tmo, logic [31:0] trig,
                           logic [31:0] free);
    drain();
    apb_write(REG_TEMPERATURE, temp);
    apb_write(REG_TIMEOUT, tmo);
    apb_write(REG_TRIGGER, trig);
    apb_write(REG_FREE_MODE, free);
  endtask

  task automatic random_measurement();
    int tlen;
    int tmo;
    int wait_n;
    int high_n;
    tlen = (sb.trig_len == 8'd0) ? 1 : int'(sb.trig_len);
    tmo = (sb.timeout == 16'd0) ? 1 : int'(sb.timeout);
    send_tick(1'b1, 1'($urandom));
    for (int i = 1; i < tlen; i++) send_tick(1'b0, 1'($urandom));
    wait_n = $urandom_range(0, (tmo < 48) ? tmo + 2 : 12);
    high_n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 700) : $urandom_range(1, 40);
    send_run(1'b0, 1'b0, wait_n);
    send_run(1'b0, 1'b1, high_n);
    send_run(1'b0, 1'b0, $urandom_range(1, 3));
  endtask

  initial begin
    int first;
    int pick;
    int budget;
    logic [31:0] tmo;
    logic [31:0] trig;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tick_valid <= 1'b0;
    tick <= '0;
    items_sent = 0;
    set_idling(IDLE_NONE);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Zero trigger length and zero timeout both act as one tick.
    configure(0, 0, 0, 0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // Temperature above range, echo during trigger, then a restart while busy.
    configure(127, 6, 2, 0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_run(1'b0, 1'b1, 2);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_run(1'b0, 1'b0, 6);

    // Free mode keeps waiting past the timeout.
    configure(100, 3, 1, 1);
    send_tick(1'b1, 1'b0);
    send_run(1'b0, 1'b0, 4);
    send_run(1'b0, 1'b1, 2);
    send_tick(1'b0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      pick = $urandom_range(0, 7);
      tmo = (pick == 0) ? 0 : (pick == 1) ? 65535 : (pick == 2) ? $urandom_range(0, 65535) :
            $urandom_range(1, 40);
      pick = $urandom_range(0, 9);
      trig = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(1, 6);
      configure($urandom_range(0, 127), tmo, trig, $urandom_range(0, 1));
      set_idling(idle_mode_t'(p % 4));
      first = items_sent;
      budget = (ITEM_TARGET - items_sent) / (PHASES - p);
      if (budget < MIN_PHASE_ITEMS) budget = MIN_PHASE_ITEMS;
      while (items_sent - first < budget) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          random_measurement();
        end else if (pick < 9) begin
          repeat ($urandom_range(1, 16)) send_tick($urandom_range(0, 7) == 0, 1'($urandom));
        end else begin
          send_tick(1'b1, 1'($urandom));
          repeat ($urandom_range(0, 8)) send_tick(1'b0, 1'($urandom));
        end
      end
    end

    drain();
    if (sb.readings_due.size() != 0) begin
      sb.report("readings missing", 64'(0), 64'(sb.readings_due.size()));
    end
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
